/* rtl/core/lagi_pkg.sv */
package lagi_pkg;

  localparam int MaxNodes   = 8;
  localparam int SampleBits = 16;
  localparam int IdxW       = $clog2(MaxNodes);
  localparam int CountW     = 4;
  localparam int SpacingW   = 7;
  localparam int QueryW     = 9;
  localparam int DiffW      = 10;
  localparam int BinomW     = 6;
  localparam int FactW      = 13;
  localparam int TermW      = 96;
  localparam int AccW       = 100;
  localparam int DenW       = 64;
  localparam int NumW       = 97;
  localparam int DivCntW    = 7;
  localparam int ResultW    = 32;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdEval  = 1'b1;

  localparam logic CfgNodeCount = 1'b0;
  localparam logic CfgSpacing   = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_WRITE,
    OP_EVAL,
    OP_LOAD,
    OP_MUL,
    OP_ACC,
    OP_DINIT,
    OP_DMUL,
    OP_ABS,
    OP_NUM,
    OP_DIV,
    OP_FIN
  } dp_op_e;

  typedef struct packed {
    dp_op_e          op;
    logic [IdxW-1:0] i;
    logic [IdxW-1:0] j;
  } dp_cmd_t;

  function automatic logic [BinomW-1:0] binom_f(input logic [IdxW-1:0] m,
                                                 input logic [IdxW-1:0] k);
    logic [BinomW-1:0] row [MaxNodes];
    logic [BinomW-1:0] nxt [MaxNodes];
    logic [BinomW-1:0] res;
    res = '0;
    for (int c = 0; c < MaxNodes; c++) begin
      row[c] = (c == 0) ? BinomW'(1) : '0;
      nxt[c] = '0;
    end
    for (int r = 0; r < MaxNodes; r++) begin
      if (IdxW'(r) == m) begin
        res = row[k];
      end
      for (int c = 0; c < MaxNodes; c++) begin
        nxt[c] = row[c] + ((c > 0) ? row[(c > 0) ? c - 1 : 0] : '0);
      end
      row = nxt;
    end
    return res;
  endfunction

  function automatic logic [FactW-1:0] fact_f(input logic [IdxW-1:0] m);
    logic [FactW-1:0] f;
    case (m)
      3'd2:    f = FactW'(2);
      3'd3:    f = FactW'(6);
      3'd4:    f = FactW'(24);
      3'd5:    f = FactW'(120);
      3'd6:    f = FactW'(720);
      3'd7:    f = FactW'(5040);
      default: f = FactW'(1);
    endcase
    return f;
  endfunction

endpackage

/* rtl/core/lagi_ctrl.sv */
module lagi_ctrl
  import lagi_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic            command_i,
  input  logic [IdxW-1:0] m_i,
  output logic            busy,
  output logic            strobe_o,
  output dp_cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_MUL, S_ACC, S_DINIT, S_DMUL, S_ABS, S_NUM, S_DIV, S_FIN
  } state_e;

  state_e             state_q;
  logic [IdxW-1:0]    i_q, j_q;
  logic [DivCntW-1:0] k_q;
  logic               done_q;

  assign busy     = (state_q != S_IDLE);
  assign strobe_o = done_q;

  always_comb begin
    cmd_o.i = i_q;
    cmd_o.j = j_q;
    unique case (state_q)
      S_IDLE: begin
        if (!start)                 cmd_o.op = OP_NONE;
        else if (command_i == CmdEval) cmd_o.op = OP_EVAL;
        else                        cmd_o.op = OP_WRITE;
      end
      S_LOAD:  cmd_o.op = OP_LOAD;
      S_MUL:   cmd_o.op = (j_q != i_q) ? OP_MUL : OP_NONE;
      S_ACC:   cmd_o.op = OP_ACC;
      S_DINIT: cmd_o.op = OP_DINIT;
      S_DMUL:  cmd_o.op = OP_DMUL;
      S_ABS:   cmd_o.op = OP_ABS;
      S_NUM:   cmd_o.op = OP_NUM;
      S_DIV:   cmd_o.op = OP_DIV;
      S_FIN:   cmd_o.op = OP_FIN;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == S_FIN);
      unique case (state_q)
        S_IDLE: begin
          if (start && command_i == CmdEval) begin
            i_q     <= '0;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          j_q     <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          if (j_q == m_i) state_q <= S_ACC;
          else            j_q <= j_q + 1'b1;
        end
        S_ACC: begin
          if (i_q == m_i) begin
            state_q <= S_DINIT;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= S_LOAD;
          end
        end
        S_DINIT: begin
          j_q     <= '0;
          state_q <= S_DMUL;
        end
        S_DMUL: begin
          if (j_q == m_i - 1'b1) state_q <= S_ABS;
          else                   j_q <= j_q + 1'b1;
        end
        S_ABS: state_q <= S_NUM;
        S_NUM: begin
          k_q     <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (k_q == DivCntW'(NumW - 1)) state_q <= S_FIN;
          else                           k_q <= k_q + 1'b1;
        end
        S_FIN: begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/lagi_dp.sv */
module lagi_dp
  import lagi_pkg::*;
(
  input  logic                      clk_i,
  input  dp_cmd_t                   cmd_i,
  input  logic [IdxW-1:0]           m_i,
  input  logic [SpacingW-1:0]       h_i,
  input  logic [IdxW-1:0]           node_index_i,
  input  logic signed [SampleBits-1:0] node_value_i,
  input  logic [QueryW-1:0]         query_x_i,
  output logic signed [ResultW-1:0] interp_value_o,
  output logic                      saturated_o
);

  logic [SampleBits-1:0] nodes_q [MaxNodes];
  logic [QueryW-1:0]     x_q;
  logic [TermW-1:0]      term_q;
  logic                  neg_q;
  logic [AccW-1:0]       acc_q;
  logic                  res_neg_q;
  logic [NumW-1:0]       num_q;
  logic [DenW-1:0]       den_q;
  logic [DenW-1:0]       rem_q;
  logic [ResultW-1:0]    quo_q;
  logic                  hi_q;
  logic [ResultW-1:0]    out_q;
  logic                  sat_q;

  logic [SampleBits-1:0] y;
  logic [SampleBits:0]   abs_y;
  logic [SampleBits+BinomW:0] y_binom;
  logic [DiffW-1:0]      jh;
  logic [DiffW:0]        diff;
  logic [DiffW-1:0]      abs_d;
  logic [DiffW-1:0]      mul_b;
  logic [TermW+DiffW-1:0] prod;
  logic [AccW-1:0]       term_ext;
  logic [DenW:0]         rem_sh;
  logic                  qbit;
  logic [ResultW-1:0]    limit;
  logic                  sat;
  logic [ResultW-1:0]    mag;

  assign y     = nodes_q[cmd_i.i];
  assign abs_y = y[SampleBits-1] ? (SampleBits+1)'(-$signed({y[SampleBits-1], y}))
                                 : {1'b0, y};
  assign y_binom = {{BinomW{1'b0}}, abs_y} * {{(SampleBits+1){1'b0}}, binom_f(m_i, cmd_i.i)};
  assign jh    = DiffW'(cmd_i.j) * DiffW'(h_i);
  assign diff  = {2'b00, x_q} - {1'b0, jh};
  assign abs_d = diff[DiffW] ? DiffW'(-diff) : diff[DiffW-1:0];
  assign mul_b = (cmd_i.op == OP_MUL) ? abs_d : DiffW'(h_i);
  assign prod  = term_q * mul_b;
  assign term_ext = AccW'(term_q);

  assign rem_sh = {rem_q, num_q[NumW-1]};
  assign qbit   = (rem_sh >= {1'b0, den_q});

  assign limit = res_neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign sat   = hi_q || (quo_q > limit);
  assign mag   = sat ? limit : quo_q;

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_WRITE: nodes_q[node_index_i] <= node_value_i;
      OP_EVAL: begin
        x_q   <= query_x_i;
        acc_q <= '0;
      end
      OP_LOAD: begin
        term_q <= TermW'(y_binom);
        neg_q  <= (m_i[0] ^ cmd_i.i[0]) ^ y[SampleBits-1];
      end
      OP_MUL: begin
        term_q <= prod[TermW-1:0];
        neg_q  <= neg_q ^ diff[DiffW];
      end
      OP_ACC:   acc_q <= neg_q ? acc_q - term_ext : acc_q + term_ext;
      OP_DINIT: term_q <= TermW'(fact_f(m_i));
      OP_DMUL:  term_q <= prod[TermW-1:0];
      OP_ABS: begin
        res_neg_q <= acc_q[AccW-1];
        if (acc_q[AccW-1]) acc_q <= -acc_q;
      end
      OP_NUM: begin
        num_q <= {acc_q[NumW-2:0], 1'b0} + NumW'(term_q);
        den_q <= {term_q[DenW-2:0], 1'b0};
        rem_q <= '0;
        quo_q <= '0;
        hi_q  <= 1'b0;
      end
      OP_DIV: begin
        rem_q <= qbit ? DenW'(rem_sh - {1'b0, den_q}) : rem_sh[DenW-1:0];
        num_q <= {num_q[NumW-2:0], 1'b0};
        quo_q <= {quo_q[ResultW-2:0], qbit};
        hi_q  <= hi_q | quo_q[ResultW-1];
      end
      OP_FIN: begin
        out_q <= res_neg_q ? -mag : mag;
        sat_q <= sat;
      end
      default: ;
    endcase
  end

  assign interp_value_o = $signed(out_q);
  assign saturated_o    = sat_q;

endmodule

/* rtl/core/lagrange_interpolator.sv */
// Equispaced Lagrange interpolator. A write item stores a signed sample for
// one node; an evaluate item returns the value of the polynomial through the
// first node_count nodes at query_x, rounded to nearest with ties away from
// zero and saturated to 32 bits. The evaluation runs the shared term
// multiplier for each node in turn and for the denominator build, then
// the 97-step restoring divider. Busy stays high until the result cycle,
// in which a new item can already be accepted; write items are taken
// whenever busy is low. The result appears for exactly one cycle with
// strobe_o high and cannot be held off, so the receiver must take it
// then. Evaluating with a node that was never written gives an undefined
// result.
module lagrange_interpolator
  import lagi_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         command_i,
  input  logic [IdxW-1:0]              node_index_i,
  input  logic signed [SampleBits-1:0] node_value_i,
  input  logic [QueryW-1:0]            query_x_i,
  output logic                         strobe_o,
  output logic signed [ResultW-1:0]    interp_value_o,
  output logic                         saturated_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [SpacingW-1:0]          cfg_data_i
);

  logic [CountW-1:0]   count_q;
  logic [SpacingW-1:0] spacing_q;
  logic [IdxW-1:0]     m;
  logic [SpacingW-1:0] h;
  dp_cmd_t             cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= CountW'(8);
      spacing_q <= SpacingW'(5);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgNodeCount: count_q   <= cfg_data_i[CountW-1:0];
        CfgSpacing:   spacing_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (count_q < CountW'(2))             m = IdxW'(1);
    else if (count_q > CountW'(MaxNodes)) m = IdxW'(MaxNodes - 1);
    else                                  m = IdxW'(count_q - 1'b1);
    h = (spacing_q == '0) ? SpacingW'(1) : spacing_q;
  end

  lagi_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .m_i       (m),
    .busy      (busy),
    .strobe_o  (strobe_o),
    .cmd_o     (cmd)
  );

  lagi_dp u_dp (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .m_i            (m),
    .h_i            (h),
    .node_index_i   (node_index_i),
    .node_value_i   (node_value_i),
    .query_x_i      (query_x_i),
    .interp_value_o (interp_value_o),
    .saturated_o    (saturated_o)
  );

endmodule
